FILE: rtl/core/matrix_local_peak_finder_defines.svh
// Assertion shorthands for the peak finder checks.
// Each macro expects signals named clock and reset in the using scope.
`ifndef MATRIX_LOCAL_PEAK_FINDER_DEFINES_SVH
`define MATRIX_LOCAL_PEAK_FINDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MLPF_ASSERT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MLPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mlpf_pkg.sv
package mlpf_pkg;

   // sample and matrix geometry
   localparam int DATA_WIDTH  = 32;
   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int DIM_WIDTH   = 11;
   localparam int TALLY_WIDTH = 21;
   localparam int ADDR_WIDTH  = $clog2(MAX_COLS);
   localparam int LINE_WIDTH  = 2 * DATA_WIDTH;

   // result fan-out per input beat and result queue sizing
   localparam int RESULTS_PER_ITEM = 4;
   localparam int RCNT_WIDTH       = $clog2(RESULTS_PER_ITEM + 1);
   localparam int RIDX_WIDTH       = $clog2(RESULTS_PER_ITEM);
   localparam int QUEUE_DEPTH      = 16;
   localparam int QPTR_WIDTH       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH       = $clog2(QUEUE_DEPTH + 1);
   localparam int QNEED_WIDTH      = QCNT_WIDTH + 1;

   // stream payload widths
   localparam int REQ_TDATA_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELDS_WIDTH = 2 * DIM_WIDTH + TALLY_WIDTH;
   localparam int RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_ROWS = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_COLS = CSR_INDEX_WIDTH'(1);

   typedef logic signed [DATA_WIDTH-1:0] sample_type;
   typedef logic [DIM_WIDTH-1:0]         dim_type;

   // most negative sample, stands in for neighbors outside the matrix
   localparam sample_type INT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   localparam dim_type MAX_ROWS_DIM = DIM_WIDTH'(MAX_ROWS);
   localparam dim_type MAX_COLS_DIM = DIM_WIDTH'(MAX_COLS);

   typedef enum logic {
      KIND_PEAK = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type                 kind;
      dim_type                  hit_row;
      dim_type                  hit_col;
      logic [TALLY_WIDTH-1:0]   total_peaks;
   } result_type;

   // one column of the line buffer: row above and the row above that
   typedef struct packed {
      sample_type prev_val;
      sample_type older_val;
   } line_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_WIDTH-1:0] addr;
      line_type              data;
   } line_wr_type;

   // item held in the compute stage with its position flags
   typedef struct packed {
      sample_type key;
      dim_type    row_pos;
      dim_type    col_pos;
      logic       has_above;
      logic       last_row;
      logic       last_col;
      logic       multi_row;
      logic       bypass_self;
      logic       bypass_prev;
   } stage_type;

   // 0 counts as 1, anything above the maximum counts as the maximum
   function automatic dim_type clamp_dim(dim_type value, dim_type max_value);
      dim_type result;
      if (value == '0) begin
         result = DIM_WIDTH'(1);
      end else if (value > max_value) begin
         result = max_value;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

FILE: rtl/core/mlpf_ram.sv
module mlpf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/mlpf_window.sv
module mlpf_window
   import mlpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic                  stage_valid,
   input  stage_type             stage,
   input  line_type              ram_data,
   input  line_type              bypass_data,
   output line_wr_type           line_wr,
   output result_type            results [RESULTS_PER_ITEM],
   output logic [RCNT_WIDTH-1:0] result_count
);

   // sliding window over the row above (left, center) and two rows up
   sample_type center_ff, center_in;
   sample_type left_ff, left_in;
   sample_type up_ff, up_in;
   // last two samples of the current row
   sample_type rc0_ff, rc0_in;
   sample_type rc1_ff, rc1_in;
   logic [TALLY_WIDTH-1:0] tally_ff, tally_in;

   line_type               look;
   logic                   first_col;
   logic                   frame_end;
   logic                   peak_a, peak_b, peak_c;
   dim_type                row1, col1;
   logic [TALLY_WIDTH-1:0] tally_sum;
   logic [RCNT_WIDTH-1:0]  slot;
   result_type             res_a, res_b, res_c, res_end;

   function automatic logic is_peak(sample_type center, sample_type up, sample_type down,
                                    sample_type left, sample_type right);
      return (center >= up) && (center >= down) && (center >= left) && (center >= right);
   endfunction

   // lookahead column: RAM data unless a write of this or the last beat is newer
   always_comb begin
      if (stage.bypass_self) begin
         look = '{prev_val: stage.key, older_val: center_ff};
      end else if (stage.bypass_prev) begin
         look = bypass_data;
      end else begin
         look = ram_data;
      end
   end

   // neighbor checks: row above, previous column of the last row, final sample
   always_comb begin
      first_col = (stage.col_pos == '0);
      frame_end = stage.last_row && stage.last_col;
      row1      = stage.row_pos + DIM_WIDTH'(1);
      col1      = stage.col_pos + DIM_WIDTH'(1);

      peak_a = stage.has_above &&
               is_peak(center_ff,
                       (stage.row_pos >= DIM_WIDTH'(2)) ? up_ff : INT_MIN,
                       stage.key,
                       first_col ? INT_MIN : left_ff,
                       stage.last_col ? INT_MIN : look.prev_val);
      peak_b = stage.last_row && !first_col &&
               is_peak(rc0_ff,
                       stage.multi_row ? left_ff : INT_MIN,
                       INT_MIN,
                       (stage.col_pos >= DIM_WIDTH'(2)) ? rc1_ff : INT_MIN,
                       stage.key);
      peak_c = frame_end &&
               is_peak(stage.key,
                       stage.multi_row ? center_ff : INT_MIN,
                       INT_MIN,
                       first_col ? INT_MIN : rc0_ff,
                       INT_MIN);

      tally_sum = tally_ff + TALLY_WIDTH'(peak_a) + TALLY_WIDTH'(peak_b)
                  + TALLY_WIDTH'(peak_c);

      res_a   = '{kind: KIND_PEAK, hit_row: stage.row_pos, hit_col: col1,
                  total_peaks: '0};
      res_b   = '{kind: KIND_PEAK, hit_row: row1, hit_col: stage.col_pos,
                  total_peaks: '0};
      res_c   = '{kind: KIND_PEAK, hit_row: row1, hit_col: col1, total_peaks: '0};
      res_end = '{kind: KIND_END, hit_row: '0, hit_col: '0, total_peaks: tally_sum};
   end

   // pack the results of this beat into the lowest slots, in report order
   always_comb begin
      for (int k = 0; k < RESULTS_PER_ITEM; k++) begin
         results[k] = '0;
      end
      slot = '0;
      if (stage_valid) begin
         if (peak_a) begin
            results[slot[RIDX_WIDTH-1:0]] = res_a;
            slot = slot + RCNT_WIDTH'(1);
         end
         if (peak_b) begin
            results[slot[RIDX_WIDTH-1:0]] = res_b;
            slot = slot + RCNT_WIDTH'(1);
         end
         if (peak_c) begin
            results[slot[RIDX_WIDTH-1:0]] = res_c;
            slot = slot + RCNT_WIDTH'(1);
         end
         if (frame_end) begin
            results[slot[RIDX_WIDTH-1:0]] = res_end;
            slot = slot + RCNT_WIDTH'(1);
         end
      end
      result_count = slot;
   end

   // line buffer update: this sample becomes the row above, center moves down
   assign line_wr = '{wr_en: stage_valid,
                      addr:  stage.col_pos[ADDR_WIDTH-1:0],
                      data:  '{prev_val: stage.key, older_val: center_ff}};

   // window shift and tally
   always_comb begin
      center_in = center_ff;
      left_in   = left_ff;
      up_in     = up_ff;
      rc0_in    = rc0_ff;
      rc1_in    = rc1_ff;
      tally_in  = tally_ff;
      if (stage_valid) begin
         left_in   = center_ff;
         center_in = look.prev_val;
         up_in     = look.older_val;
         rc1_in    = rc0_ff;
         rc0_in    = stage.key;
         tally_in  = tally_sum;
         if (frame_end) begin
            rc0_in   = '0;
            rc1_in   = '0;
            tally_in = '0;
         end
      end
      if (restart) begin
         rc0_in   = '0;
         rc1_in   = '0;
         tally_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rc0_ff   <= '0;
         rc1_ff   <= '0;
         tally_ff <= '0;
      end else begin
         rc0_ff   <= rc0_in;
         rc1_ff   <= rc1_in;
         tally_ff <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      center_ff <= center_in;
      left_ff   <= left_in;
      up_ff     <= up_in;
   end

endmodule

FILE: rtl/core/mlpf_result_queue.sv
module mlpf_result_queue
   import mlpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [RCNT_WIDTH-1:0] push_count,
   input  result_type            push_data [RESULTS_PER_ITEM],
   input  logic                  pop,
   output result_type            head,
   output logic                  head_valid,
   output logic [QCNT_WIDTH-1:0] level
);

   result_type            entries_ff [QUEUE_DEPTH];
   result_type            entries_in [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] level_ff, level_in;

   // up to four pushes per cycle at consecutive slots, one pop
   always_comb begin
      entries_in = entries_ff;
      for (int k = 0; k < RESULTS_PER_ITEM; k++) begin
         if (RCNT_WIDTH'(k) < push_count) begin
            entries_in[wr_ptr_ff + QPTR_WIDTH'(k)] = push_data[k];
         end
      end
      wr_ptr_in = wr_ptr_ff + QPTR_WIDTH'(push_count);
      rd_ptr_in = rd_ptr_ff + QPTR_WIDTH'(pop);
      level_in  = level_ff + QCNT_WIDTH'(push_count) - QCNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = (level_ff != '0);
   assign level      = level_ff;

endmodule

FILE: rtl/core/matrix_local_peak_finder.sv
// Four-neighbor local peak finder over a row-major matrix stream.
// req_*: one signed sample per beat, rows of num_cols samples, num_rows rows per
//   frame. rsp_*: peak reports (tuser 0) carrying 1-based row and column, and
//   one end-of-frame beat (tuser 1, tlast 1) carrying the frame's peak count.
// csr_*: write num_rows (index 0) or num_cols (index 1); either write restarts
//   the frame. Other indexes are ignored. Write only while the block is idle.
// Throughput: one sample per cycle while req_tready is high. A peak in an inner
//   row is reported with the sample below it, a last-row peak with the sample to
//   its right; the final sample yields up to three peaks plus the end-of-frame
//   beat. A result passes the input register, with the line buffer read at the
//   accepting edge, then is computed into the 16-entry result queue, where it
//   waits behind any earlier results. Results drain at one per cycle while
//   rsp_tready is high. req_tready falls when the queue, plus the beat in the
//   compute stage, could not take four more results, so a stalled receiver
//   backs up the input once nine (stage busy) to thirteen results wait.
// Reset clears the queue and frame position and sets both sizes to 1; the line
//   buffer needs no clearing, every entry is written before it is read.
module matrix_local_peak_finder
   import mlpf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // sample_value[31:0]
   input  logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // hit_row[10:0], hit_col[21:11], total_peaks[42:22], zero pad
   output logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // item_kind[0]
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [DIM_WIDTH-1:0]       csr_wr_data
);

   dim_type     num_rows_ff, num_rows_in;
   dim_type     num_cols_ff, num_cols_in;
   dim_type     row_pos_ff, row_pos_in;
   dim_type     col_pos_ff, col_pos_in;
   stage_type   stage_ff, stage_in;
   logic        stage_valid_ff, stage_valid_in;
   line_type    bypass_data_ff, bypass_data_in;

   logic                   accept;
   logic                   restart;
   logic                   last_row;
   logic                   last_col;
   logic [ADDR_WIDTH-1:0]  look_addr;
   logic [QNEED_WIDTH-1:0] queue_need;
   line_wr_type            line_wr;
   line_type               ram_data;
   result_type             results [RESULTS_PER_ITEM];
   logic [RCNT_WIDTH-1:0]  result_count;
   result_type             head;
   logic                   head_valid;
   logic [QCNT_WIDTH-1:0]  queue_level;

   // input side handshake: room for four more results after the stage drains
   always_comb begin
      queue_need = QNEED_WIDTH'(queue_level)
                   + (stage_valid_ff ? QNEED_WIDTH'(RESULTS_PER_ITEM) : '0);
      req_tready = (queue_need <= QNEED_WIDTH'(QUEUE_DEPTH - RESULTS_PER_ITEM));
   end
   assign accept  = req_tvalid && req_tready;
   assign restart = csr_wr_en && ((csr_index == CSR_NUM_ROWS) || (csr_index == CSR_NUM_COLS));

   // position of the incoming sample, lookahead column for the line buffer
   always_comb begin
      last_row  = (row_pos_ff + DIM_WIDTH'(1)) == num_rows_ff;
      last_col  = (col_pos_ff + DIM_WIDTH'(1)) == num_cols_ff;
      look_addr = last_col ? '0 : col_pos_ff[ADDR_WIDTH-1:0] + ADDR_WIDTH'(1);
   end

   // size registers and frame counters
   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      if (csr_wr_en && (csr_index == CSR_NUM_ROWS)) begin
         num_rows_in = clamp_dim(csr_wr_data, MAX_ROWS_DIM);
      end
      if (csr_wr_en && (csr_index == CSR_NUM_COLS)) begin
         num_cols_in = clamp_dim(csr_wr_data, MAX_COLS_DIM);
      end
      if (restart) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_pos_in = '0;
            row_pos_in = last_row ? '0 : row_pos_ff + DIM_WIDTH'(1);
         end else begin
            col_pos_in = col_pos_ff + DIM_WIDTH'(1);
         end
      end
   end

   // compute stage register, plus capture of a line write the RAM read misses
   always_comb begin
      stage_valid_in = accept;
      stage_in       = stage_ff;
      bypass_data_in = bypass_data_ff;
      if (accept) begin
         stage_in.key         = sample_type'(req_tdata[DATA_WIDTH-1:0]);
         stage_in.row_pos     = row_pos_ff;
         stage_in.col_pos     = col_pos_ff;
         stage_in.has_above   = (row_pos_ff != '0);
         stage_in.last_row    = last_row;
         stage_in.last_col    = last_col;
         stage_in.multi_row   = (num_rows_ff != DIM_WIDTH'(1));
         stage_in.bypass_self = last_col && (col_pos_ff == '0);
         stage_in.bypass_prev = line_wr.wr_en && (line_wr.addr == look_addr);
         bypass_data_in       = line_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff    <= DIM_WIDTH'(1);
         num_cols_ff    <= DIM_WIDTH'(1);
         row_pos_ff     <= '0;
         col_pos_ff     <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         num_rows_ff    <= num_rows_in;
         num_cols_ff    <= num_cols_in;
         row_pos_ff     <= row_pos_in;
         col_pos_ff     <= col_pos_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff       <= stage_in;
      bypass_data_ff <= bypass_data_in;
   end

   // line buffer: both earlier rows side by side, one column per entry
   mlpf_ram #(
      .WIDTH(LINE_WIDTH),
      .DEPTH(MAX_COLS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_wr.wr_en),
      .wr_addr (line_wr.addr),
      .wr_data (line_wr.data),
      .rd_en   (accept),
      .rd_addr (look_addr),
      .rd_data (ram_data)
   );

   mlpf_window u_window (
      .clock        (clock),
      .reset        (reset),
      .restart      (restart),
      .stage_valid  (stage_valid_ff),
      .stage        (stage_ff),
      .ram_data     (ram_data),
      .bypass_data  (bypass_data_ff),
      .line_wr      (line_wr),
      .results      (results),
      .result_count (result_count)
   );

   mlpf_result_queue u_result_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (result_count),
      .push_data  (results),
      .pop        (rsp_tvalid && rsp_tready),
      .head       (head),
      .head_valid (head_valid),
      .level      (queue_level)
   );

   // output beat straight from the queue head; end of frame is the last beat
   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = RSP_TDATA_WIDTH'({head.total_peaks, head.hit_col, head.hit_row});
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = (head.kind == KIND_END);

endmodule

FILE: rtl/core/mlpf_checker.sv
`include "matrix_local_peak_finder_defines.svh"

module mlpf_checker
   import mlpf_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input logic                       rsp_tuser,
   input logic                       rsp_tlast,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready
);

   dim_type                row_f;
   dim_type                col_f;
   logic [TALLY_WIDTH-1:0] total_f;

   assign row_f   = rsp_tdata[DIM_WIDTH-1:0];
   assign col_f   = rsp_tdata[2*DIM_WIDTH-1:DIM_WIDTH];
   assign total_f = rsp_tdata[RSP_FIELDS_WIDTH-1:2*DIM_WIDTH];

   // stalled result beat holds
   `MLPF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result beat changed")

   // end-of-frame kind and tlast go together
   `MLPF_ASSERT(a_last_kind, rsp_tvalid, rsp_tlast == rsp_tuser, "tlast does not match item kind")

   // peak reports carry a 1-based position and no count
   `MLPF_ASSERT(a_peak_fields, rsp_tvalid && !rsp_tlast, (row_f != '0) && (col_f != '0) && (total_f == '0), "bad peak report fields")

   // end-of-frame beat carries no position
   `MLPF_ASSERT(a_end_fields, rsp_tvalid && rsp_tlast, (row_f == '0) && (col_f == '0), "bad end-of-frame fields")

   // nothing pending right after reset
   `MLPF_ASSERT(a_reset_empty, $past(reset), !rsp_tvalid, "result beat right after reset")

endmodule

bind matrix_local_peak_finder mlpf_checker u_mlpf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
